/* src/tdiff_pkg.sv */
// ----------------------------------------------------------------------------
// tdiff_pkg
// Shared types, register map, control word layout and the microprogram
// of the third-order tracking differentiator.
// ----------------------------------------------------------------------------
package tdiff_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Configuration port
  localparam int CFG_DATA_W = 31;
  localparam int CFG_ADDR_W = 2;
  localparam int GAIN_W     = 31;
  localparam int DT_W       = 17;
  localparam int LIM_W      = 31;

  localparam logic [CFG_ADDR_W-1:0] REG_GAIN    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DT      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_VEL = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ACC = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_RST = 31'd655360;
  localparam logic [DT_W-1:0]   DT_RST   = 17'd66;
  localparam logic [LIM_W-1:0]  LIM_RST  = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [DT_W-1:0]   dt;
    logic [LIM_W-1:0]  max_vel;
    logic [LIM_W-1:0]  max_acc;
  } cfg_regs_t;

  // ALU operations
  typedef logic [2:0] op_t;
  localparam op_t OP_NONE  = 3'd0;
  localparam op_t OP_ADD   = 3'd1;
  localparam op_t OP_SUB   = 3'd2;
  localparam op_t OP_CLAMP = 3'd3;
  localparam op_t OP_PROD  = 3'd4;

  // Operand sources and destinations
  typedef logic [3:0] sel_t;
  localparam sel_t RS_ZERO = 4'd0;
  localparam sel_t RS_IN   = 4'd1;
  localparam sel_t RS_R    = 4'd2;
  localparam sel_t RS_DT   = 4'd3;
  localparam sel_t RS_LV   = 4'd4;
  localparam sel_t RS_LA   = 4'd5;
  localparam sel_t RS_POS  = 4'd6;
  localparam sel_t RS_VEL  = 4'd7;
  localparam sel_t RS_ACC  = 4'd8;
  localparam sel_t RS_E    = 4'd9;
  localparam sel_t RS_R2   = 4'd10;
  localparam sel_t RS_R3   = 4'd11;
  localparam sel_t RS_K1   = 4'd12;
  localparam sel_t RS_K2   = 4'd13;
  localparam sel_t RS_JERK = 4'd14;
  localparam sel_t RS_T    = 4'd15;

  // Wait conditions: the step repeats while its condition holds
  typedef logic [1:0] hold_t;
  localparam hold_t HOLD_NONE = 2'd0;
  localparam hold_t HOLD_IN   = 2'd1;
  localparam hold_t HOLD_MUL  = 2'd2;
  localparam hold_t HOLD_OUT  = 2'd3;

  typedef struct packed {
    op_t   op;
    sel_t  src_a;
    sel_t  src_b;
    sel_t  dst;
    logic  mul_go;
    sel_t  mul_a;
    sel_t  mul_b;
    hold_t hold;
    logic  out_load;
    logic  ret;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic mul_busy;
    logic out_full;
  } seq_status_t;

  localparam int PROG_LEN = 26;
  localparam int STEP_W   = $clog2(PROG_LEN);
  typedef logic [STEP_W-1:0] step_t;

  localparam int MUL_STEPS = 4;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

  function automatic ctrl_word_t mk(op_t op, sel_t a, sel_t b, sel_t dst,
                                    logic mg, sel_t ma, sel_t mb,
                                    hold_t hold, logic outl, logic ret);
    ctrl_word_t w;
    w.op       = op;
    w.src_a    = a;
    w.src_b    = b;
    w.dst      = dst;
    w.mul_go   = mg;
    w.mul_a    = ma;
    w.mul_b    = mb;
    w.hold     = hold;
    w.out_load = outl;
    w.ret      = ret;
    return w;
  endfunction

  // Microprogram: one control word per step
  function automatic ctrl_word_t prog_rom(step_t s);
    ctrl_word_t w;
    case (s)
      // take the request, form the error, start r*r
      5'd0:  w = mk(OP_SUB,   RS_POS,  RS_IN,   RS_E,    1'b1, RS_R,   RS_R,
                    HOLD_IN,   1'b0, 1'b0);
      5'd1:  w = mk(OP_PROD,  RS_ZERO, RS_ZERO, RS_R2,   1'b0, RS_ZERO, RS_ZERO,
                    HOLD_MUL,  1'b0, 1'b0);
      5'd2:  w = mk(OP_ADD,   RS_R,    RS_R,    RS_K1,   1'b1, RS_R2,  RS_R,
                    HOLD_NONE, 1'b0, 1'b0);
      5'd3:  w = mk(OP_ADD,   RS_K1,   RS_R,    RS_K1,   1'b0, RS_ZERO, RS_ZERO,
                    HOLD_NONE, 1'b0, 1'b0);
      5'd4:  w = mk(OP_ADD,   RS_R2,   RS_R2,   RS_K2,   1'b0, RS_ZERO, RS_ZERO,
                    HOLD_NONE, 1'b0, 1'b0);
      5'd5:  w = mk(OP_ADD,   RS_K2,   RS_R2,   RS_K2,   1'b0, RS_ZERO, RS_ZERO,
                    HOLD_NONE, 1'b0, 1'b0);
      5'd6:  w = mk(OP_PROD,  RS_ZERO, RS_ZERO, RS_R3,   1'b0, RS_ZERO, RS_ZERO,
                    HOLD_MUL,  1'b0, 1'b0);
      5'd7:  w = mk(OP_NONE,  RS_ZERO, RS_ZERO, RS_ZERO, 1'b1, RS_R3,  RS_E,
                    HOLD_NONE, 1'b0, 1'b0);
      5'd8:  w = mk(OP_PROD,  RS_ZERO, RS_ZERO, RS_T,    1'b0, RS_ZERO, RS_ZERO,
                    HOLD_MUL,  1'b0, 1'b0);
      5'd9:  w = mk(OP_SUB,   RS_ZERO, RS_T,    RS_JERK, 1'b1, RS_K2,  RS_VEL,
                    HOLD_NONE, 1'b0, 1'b0);
      5'd10: w = mk(OP_PROD,  RS_ZERO, RS_ZERO, RS_T,    1'b0, RS_ZERO, RS_ZERO,
                    HOLD_MUL,  1'b0, 1'b0);
      5'd11: w = mk(OP_SUB,   RS_JERK, RS_T,    RS_JERK, 1'b1, RS_K1,  RS_ACC,
                    HOLD_NONE, 1'b0, 1'b0);
      5'd12: w = mk(OP_PROD,  RS_ZERO, RS_ZERO, RS_T,    1'b0, RS_ZERO, RS_ZERO,
                    HOLD_MUL,  1'b0, 1'b0);
      5'd13: w = mk(OP_SUB,   RS_JERK, RS_T,    RS_JERK, 1'b0, RS_ZERO, RS_ZERO,
                    HOLD_NONE, 1'b0, 1'b0);
      // integrate acceleration
      5'd14: w = mk(OP_NONE,  RS_ZERO, RS_ZERO, RS_ZERO, 1'b1, RS_JERK, RS_DT,
                    HOLD_NONE, 1'b0, 1'b0);
      5'd15: w = mk(OP_PROD,  RS_ZERO, RS_ZERO, RS_T,    1'b0, RS_ZERO, RS_ZERO,
                    HOLD_MUL,  1'b0, 1'b0);
      5'd16: w = mk(OP_ADD,   RS_ACC,  RS_T,    RS_ACC,  1'b0, RS_ZERO, RS_ZERO,
                    HOLD_NONE, 1'b0, 1'b0);
      5'd17: w = mk(OP_CLAMP, RS_ACC,  RS_LA,   RS_ACC,  1'b0, RS_ZERO, RS_ZERO,
                    HOLD_NONE, 1'b0, 1'b0);
      // integrate velocity
      5'd18: w = mk(OP_NONE,  RS_ZERO, RS_ZERO, RS_ZERO, 1'b1, RS_ACC, RS_DT,
                    HOLD_NONE, 1'b0, 1'b0);
      5'd19: w = mk(OP_PROD,  RS_ZERO, RS_ZERO, RS_T,    1'b0, RS_ZERO, RS_ZERO,
                    HOLD_MUL,  1'b0, 1'b0);
      5'd20: w = mk(OP_ADD,   RS_VEL,  RS_T,    RS_VEL,  1'b0, RS_ZERO, RS_ZERO,
                    HOLD_NONE, 1'b0, 1'b0);
      5'd21: w = mk(OP_CLAMP, RS_VEL,  RS_LV,   RS_VEL,  1'b0, RS_ZERO, RS_ZERO,
                    HOLD_NONE, 1'b0, 1'b0);
      // integrate position
      5'd22: w = mk(OP_NONE,  RS_ZERO, RS_ZERO, RS_ZERO, 1'b1, RS_VEL, RS_DT,
                    HOLD_NONE, 1'b0, 1'b0);
      5'd23: w = mk(OP_PROD,  RS_ZERO, RS_ZERO, RS_T,    1'b0, RS_ZERO, RS_ZERO,
                    HOLD_MUL,  1'b0, 1'b0);
      5'd24: w = mk(OP_ADD,   RS_POS,  RS_T,    RS_POS,  1'b0, RS_ZERO, RS_ZERO,
                    HOLD_NONE, 1'b0, 1'b0);
      // hand the result to the output register and return
      5'd25: w = mk(OP_NONE,  RS_ZERO, RS_ZERO, RS_ZERO, 1'b0, RS_ZERO, RS_ZERO,
                    HOLD_OUT,  1'b1, 1'b1);
      default: w = mk(OP_NONE, RS_ZERO, RS_ZERO, RS_ZERO, 1'b0, RS_ZERO, RS_ZERO,
                      HOLD_NONE, 1'b0, 1'b1);
    endcase
    return w;
  endfunction

endpackage

/* src/tdiff_mul.sv */
// ----------------------------------------------------------------------------
// tdiff_mul
// Shared fixed-point multiplier: sign-magnitude, four half-width partial
// products accumulated in turn, truncating shift and saturation.
// ----------------------------------------------------------------------------
module tdiff_mul import tdiff_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic                         busy,
  output logic signed [DATA_WIDTH-1:0] prod
);

  localparam int W  = DATA_WIDTH;
  localparam int H  = (W + 1) / 2;
  localparam int PW = 2 * W;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]         xm_r, xm_nxt, ym_r, ym_nxt;
  logic                 neg_r, neg_nxt;
  logic [PW-1:0]        acc_r, acc_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [W-1:0]         prod_r, prod_nxt;

  logic [H-1:0]   dx, dy;
  logic [2*H-1:0] pp;
  logic [PW-1:0]  pp_sh;
  logic [PW-1:0]  mag;
  logic [W-1:0]   mag_w;
  logic           ovf;

  always_comb begin
    dx = cnt_r[1] ? H'(xm_r >> H) : xm_r[H-1:0];
    dy = cnt_r[0] ? H'(ym_r >> H) : ym_r[H-1:0];
    pp = dx * dy;
    case (cnt_r[1:0])
      2'd0:    pp_sh = PW'(pp);
      2'd3:    pp_sh = PW'(pp) << (2 * H);
      default: pp_sh = PW'(pp) << H;
    endcase
    mag   = acc_r >> FRAC_BITS;
    mag_w = mag[W-1:0];
    ovf   = |(acc_r >> (FRAC_BITS + W - 1));
  end

  always_comb begin
    xm_nxt   = xm_r;
    ym_nxt   = ym_r;
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    prod_nxt = prod_r;
    if (start) begin
      xm_nxt   = a[W-1] ? (~a + 1'b1) : a;
      ym_nxt   = b[W-1] ? (~b + 1'b1) : b;
      neg_nxt  = a[W-1] ^ b[W-1];
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == MUL_CNT_W'(MUL_STEPS)) begin
        // truncate toward zero on the magnitude, then saturate
        if (ovf) begin
          prod_nxt = neg_r ? WMIN : WMAX;
        end else begin
          prod_nxt = neg_r ? (~mag_w + 1'b1) : mag_w;
        end
        busy_nxt = 1'b0;
      end else begin
        acc_nxt = acc_r + pp_sh;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xm_r   <= xm_nxt;
    ym_r   <= ym_nxt;
    neg_r  <= neg_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
  end

  assign busy = busy_r;
  assign prod = prod_r;

endmodule

/* src/tdiff_dp.sv */
// ----------------------------------------------------------------------------
// tdiff_dp
// Datapath: state and scratch registers, saturating add/subtract, symmetric
// clamp and the shared multiplier, all steered by the current control word.
// ----------------------------------------------------------------------------
module tdiff_dp import tdiff_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cfg_regs_t                    cfg,
  input  ctrl_word_t                   cw,
  input  logic                         fire,
  input  logic signed [DATA_WIDTH-1:0] in_target,
  output logic                         mul_busy,
  output logic signed [DATA_WIDTH-1:0] pos,
  output logic signed [DATA_WIDTH-1:0] vel,
  output logic signed [DATA_WIDTH-1:0] acc
);

  localparam int W  = DATA_WIDTH;
  localparam int XW = (W > LIM_W) ? W : LIM_W;
  localparam int DW = (W > DT_W) ? W : DT_W;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0] pos_r, pos_nxt, vel_r, vel_nxt, acc_r, acc_nxt;
  logic signed [W-1:0] e_r, e_nxt, r2_r, r2_nxt, r3_r, r3_nxt;
  logic signed [W-1:0] k1_r, k1_nxt, k2_r, k2_nxt, jerk_r, jerk_nxt, t_r, t_nxt;

  logic signed [W-1:0] r_val, dt_val, lv_val, la_val;
  logic signed [W-1:0] op_a, op_b, mul_a, mul_b, mul_prod, alu_res, neg_b;
  logic signed [W:0]   sum, diff;

  // register values above the word range read as the largest word
  always_comb begin
    r_val  = (XW'(cfg.gain) > XW'(WMAX)) ? WMAX : W'(cfg.gain);
    dt_val = (DW'(cfg.dt) > DW'(WMAX)) ? WMAX : W'(cfg.dt);
    lv_val = (XW'(cfg.max_vel) > XW'(WMAX)) ? WMAX : W'(cfg.max_vel);
    la_val = (XW'(cfg.max_acc) > XW'(WMAX)) ? WMAX : W'(cfg.max_acc);
  end

  function automatic logic signed [W-1:0] rd(sel_t s);
    logic signed [W-1:0] v;
    case (s)
      RS_ZERO: v = '0;
      RS_IN:   v = in_target;
      RS_R:    v = r_val;
      RS_DT:   v = dt_val;
      RS_LV:   v = lv_val;
      RS_LA:   v = la_val;
      RS_POS:  v = pos_r;
      RS_VEL:  v = vel_r;
      RS_ACC:  v = acc_r;
      RS_E:    v = e_r;
      RS_R2:   v = r2_r;
      RS_R3:   v = r3_r;
      RS_K1:   v = k1_r;
      RS_K2:   v = k2_r;
      RS_JERK: v = jerk_r;
      default: v = t_r;
    endcase
    return v;
  endfunction

  function automatic logic signed [W-1:0] sat(logic signed [W:0] x);
    logic signed [W-1:0] v;
    if (x[W] != x[W-1]) begin
      v = x[W] ? WMIN : WMAX;
    end else begin
      v = x[W-1:0];
    end
    return v;
  endfunction

  always_comb begin
    op_a  = rd(cw.src_a);
    op_b  = rd(cw.src_b);
    mul_a = rd(cw.mul_a);
    mul_b = rd(cw.mul_b);
    sum   = {op_a[W-1], op_a} + {op_b[W-1], op_b};
    diff  = {op_a[W-1], op_a} - {op_b[W-1], op_b};
    neg_b = -op_b;
    case (cw.op)
      OP_ADD:   alu_res = sat(sum);
      OP_SUB:   alu_res = sat(diff);
      OP_CLAMP: begin
        // limit is never negative
        if (op_a > op_b) begin
          alu_res = op_b;
        end else if (op_a < neg_b) begin
          alu_res = neg_b;
        end else begin
          alu_res = op_a;
        end
      end
      OP_PROD:  alu_res = mul_prod;
      default:  alu_res = '0;
    endcase
  end

  always_comb begin
    pos_nxt  = pos_r;
    vel_nxt  = vel_r;
    acc_nxt  = acc_r;
    e_nxt    = e_r;
    r2_nxt   = r2_r;
    r3_nxt   = r3_r;
    k1_nxt   = k1_r;
    k2_nxt   = k2_r;
    jerk_nxt = jerk_r;
    t_nxt    = t_r;
    if (fire && (cw.op != OP_NONE)) begin
      unique case (cw.dst)
        RS_POS:  pos_nxt  = alu_res;
        RS_VEL:  vel_nxt  = alu_res;
        RS_ACC:  acc_nxt  = alu_res;
        RS_E:    e_nxt    = alu_res;
        RS_R2:   r2_nxt   = alu_res;
        RS_R3:   r3_nxt   = alu_res;
        RS_K1:   k1_nxt   = alu_res;
        RS_K2:   k2_nxt   = alu_res;
        RS_JERK: jerk_nxt = alu_res;
        RS_T:    t_nxt    = alu_res;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      vel_r <= '0;
      acc_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      vel_r <= vel_nxt;
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r    <= e_nxt;
    r2_r   <= r2_nxt;
    r3_r   <= r3_nxt;
    k1_r   <= k1_nxt;
    k2_r   <= k2_nxt;
    jerk_r <= jerk_nxt;
    t_r    <= t_nxt;
  end

  tdiff_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fire && cw.mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .prod  (mul_prod)
  );

  assign pos = pos_r;
  assign vel = vel_r;
  assign acc = acc_r;

endmodule

/* src/tdiff_seq.sv */
// ----------------------------------------------------------------------------
// tdiff_seq
// Microcode sequencer: step counter over the program table, a step repeats
// while its wait condition holds, the last step returns to the start.
// ----------------------------------------------------------------------------
module tdiff_seq import tdiff_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  seq_status_t status,
  output ctrl_word_t  cw,
  output logic        fire
);

  step_t step_r, step_nxt;
  logic  held;

  assign cw = prog_rom(step_r);

  always_comb begin
    unique case (cw.hold)
      HOLD_NONE: held = 1'b0;
      HOLD_IN:   held = !status.in_valid;
      HOLD_MUL:  held = status.mul_busy;
      HOLD_OUT:  held = status.out_full;
      default:   held = 1'b0;
    endcase
  end

  assign fire = !held;

  always_comb begin
    step_nxt = step_r;
    if (fire) begin
      step_nxt = cw.ret ? '0 : step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

/* src/third_order_tracking_differentiator.sv */
// ----------------------------------------------------------------------------
// third_order_tracking_differentiator
// Third-order linear tracking differentiator in signed fixed point.
// A request runs eight products in turn through the one shared multiplier, and
// only one request is in work at a time: the next is taken once the result has
// gone into the output register, which waits while that register is untaken.
// Reset clears position, velocity and acceleration and loads register defaults.
// ----------------------------------------------------------------------------
module third_order_tracking_differentiator import tdiff_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_target,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_position,
  output logic signed [DATA_WIDTH-1:0] out_velocity,
  output logic signed [DATA_WIDTH-1:0] out_acceleration
);

  cfg_regs_t   cfg_r, cfg_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic signed [DATA_WIDTH-1:0] out_pos_r, out_pos_nxt;
  logic signed [DATA_WIDTH-1:0] out_vel_r, out_vel_nxt;
  logic signed [DATA_WIDTH-1:0] out_acc_r, out_acc_nxt;

  ctrl_word_t  cw;
  logic        fire, mul_busy, out_full, load;
  seq_status_t status;
  logic signed [DATA_WIDTH-1:0] st_pos, st_vel, st_acc;

  // configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_GAIN:    cfg_nxt.gain    = cfg_wdata[GAIN_W-1:0];
        REG_DT:      cfg_nxt.dt      = cfg_wdata[DT_W-1:0];
        REG_MAX_VEL: cfg_nxt.max_vel = cfg_wdata[LIM_W-1:0];
        REG_MAX_ACC: cfg_nxt.max_acc = cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain    <= GAIN_RST;
      cfg_r.dt      <= DT_RST;
      cfg_r.max_vel <= LIM_RST;
      cfg_r.max_acc <= LIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign out_full = out_valid_r && !out_ready;
  assign status   = '{in_valid: in_valid, mul_busy: mul_busy, out_full: out_full};
  assign in_ready = (cw.hold == HOLD_IN);
  assign load     = fire && cw.out_load;

  tdiff_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cw     (cw),
    .fire   (fire)
  );

  tdiff_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cw        (cw),
    .fire      (fire),
    .in_target (in_target),
    .mul_busy  (mul_busy),
    .pos       (st_pos),
    .vel       (st_vel),
    .acc       (st_acc)
  );

  // output register: hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_vel_nxt   = out_vel_r;
    out_acc_nxt   = out_acc_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_pos_nxt   = st_pos;
      out_vel_nxt   = st_vel;
      out_acc_nxt   = st_acc;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pos_r <= out_pos_nxt;
    out_vel_r <= out_vel_nxt;
    out_acc_r <= out_acc_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_position     = out_pos_r;
  assign out_velocity     = out_vel_r;
  assign out_acceleration = out_acc_r;

  a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !out_full)
    else $error("result loaded over an untaken result");

  a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cw.mul_go) |-> !mul_busy)
    else $error("multiplier started while busy");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in work");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(load))
    else $error("output valid without a result load");

endmodule
